// ===== design/dfc_pkg.sv =====
// Shared types, constants and pattern tables of the discovery frame classifier.
// Depends on nothing; every other design file refers to it by scoped names.
`default_nettype none

package dfc_pkg;

    // Widths of the word fields.
    localparam int BYTE_W   = 8;
    localparam int CLASS_W  = 4;
    localparam int OFFSET_W = 5;
    localparam int LENGTH_W = 11;
    localparam int COUNT_W  = 32;
    localparam int LENF_W   = 16;
    localparam int NUM_GRP  = 3;
    localparam int HDR_W    = 5;

    // Frame byte limit; shorter frames are counted exactly, frames this long or longer saturate the count.
    localparam int MAX_FRAME_BYTES = 2048;
    localparam int LEN_CAP_INT     = (MAX_FRAME_BYTES - 1 < 2047) ? (MAX_FRAME_BYTES - 1) : 2047;
    localparam logic [LENGTH_W-1:0] LEN_CAP = LENGTH_W'(LEN_CAP_INT);

    // Byte positions of the header fields.
    localparam logic [LENGTH_W-1:0] POS_MAC_END  = LENGTH_W'(6);
    localparam logic [LENGTH_W-1:0] POS_TYPE_HI  = LENGTH_W'(12);
    localparam logic [LENGTH_W-1:0] POS_TYPE_LO  = LENGTH_W'(13);
    localparam logic [LENGTH_W-1:0] POS_LLC      = LENGTH_W'(14);
    localparam logic [LENGTH_W-1:0] POS_SNAP     = LENGTH_W'(17);
    localparam logic [LENGTH_W-1:0] POS_SNAP_END = LENGTH_W'(22);

    // Payload offsets reported with the result.
    localparam logic [OFFSET_W-1:0] OFF_ETH  = OFFSET_W'(12);
    localparam logic [OFFSET_W-1:0] OFF_LLC  = OFFSET_W'(14);
    localparam logic [OFFSET_W-1:0] OFF_SNAP = OFFSET_W'(22);

    // Header flag bits.
    localparam int HDR_TYPE = 0;
    localparam int HDR_LLC  = 1;
    localparam int HDR_SNAP = 2;

    typedef enum logic [CLASS_W-1:0] {
        CLS_CDP          = 4'd0,
        CLS_EDP          = 4'd1,
        CLS_LLDP_SNAP    = 4'd2,
        CLS_LLDP_ETH     = 4'd3,
        CLS_ICMP         = 4'd4,
        CLS_OTHER        = 4'd5,
        CLS_INCOMPLETE   = 4'd6,
        CLS_UNKNOWN_LLC  = 4'd7,
        CLS_UNKNOWN_SNAP = 4'd8
    } frame_class_t;

    // Group destination addresses: CDP, EDP, LLDP.
    localparam logic [BYTE_W-1:0] MAC_PAT [NUM_GRP][6] = '{
        '{8'h01, 8'h00, 8'h0c, 8'hcc, 8'hcc, 8'hcc},
        '{8'h00, 8'he0, 8'h2b, 8'h00, 8'h00, 8'h00},
        '{8'h01, 8'h80, 8'hc2, 8'h00, 8'h00, 8'h0e}
    };
    localparam logic [BYTE_W-1:0] TYPE_PAT [2] = '{8'h88, 8'hcc};
    localparam logic [BYTE_W-1:0] LLC_PAT [3]  = '{8'haa, 8'haa, 8'h03};
    localparam logic [BYTE_W-1:0] SNAP_PAT [NUM_GRP][5] = '{
        '{8'h00, 8'h00, 8'h0c, 8'h20, 8'h00},
        '{8'h00, 8'he0, 8'h2b, 8'h00, 8'hbb},
        '{8'h00, 8'h00, 8'h00, 8'h88, 8'hcc}
    };

    // Frame status after the current word has been taken into account.
    typedef struct packed {
        logic [LENGTH_W-1:0] count;
        logic [LENF_W-1:0]   length_field;
        logic [NUM_GRP-1:0]  mac_flags;
        logic [HDR_W-1:0]    hdr_flags;
    } frame_status_t;

    // Verdict of the classifier for a finished frame.
    typedef struct packed {
        frame_class_t        frame_class;
        logic [OFFSET_W-1:0] payload_offset;
        logic                counted;
    } verdict_t;

endpackage

`default_nettype wire

// ===== design/dfc_channels.sv =====
// Handshake channels of the discovery frame classifier: frame bytes in, verdicts out.
// Depends on dfc_pkg for the field widths.
`default_nettype none

interface dfc_byte_if;
    logic                       valid;
    logic                       ready;
    logic [dfc_pkg::BYTE_W-1:0] data_byte;
    logic                       last_byte;
    logic                       icmp_reply;

    modport source (output valid, output data_byte, output last_byte, output icmp_reply,
                    input ready);
    modport sink   (input valid, input data_byte, input last_byte, input icmp_reply,
                    output ready);
endinterface

interface dfc_result_if;
    logic                         valid;
    logic                         ready;
    logic [dfc_pkg::CLASS_W-1:0]  frame_class;
    logic [dfc_pkg::OFFSET_W-1:0] payload_offset;
    logic [dfc_pkg::LENGTH_W-1:0] frame_length;
    logic [dfc_pkg::COUNT_W-1:0]  accepted_count;

    modport source (output valid, output frame_class, output payload_offset,
                    output frame_length, output accepted_count, input ready);
    modport sink   (input valid, input frame_class, input payload_offset,
                    input frame_length, input accepted_count, output ready);
endinterface

`default_nettype wire

// ===== design/dfc_frame_track.sv =====
// Per-frame tracking: byte count, length field and pattern match flags.
// Depends on dfc_pkg for the pattern tables and the status struct.
`default_nettype none

module dfc_frame_track
#(
    parameter int MAX_FRAME_BYTES = dfc_pkg::MAX_FRAME_BYTES
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       take,
    input  wire logic [dfc_pkg::BYTE_W-1:0] data_byte,
    input  wire logic                       last_byte,
    output dfc_pkg::frame_status_t          status
);

    // The byte count stops one short of the frame limit, and never beyond its own width.
    localparam int LEN_TOP = (1 << dfc_pkg::LENGTH_W) - 1;
    localparam logic [dfc_pkg::LENGTH_W-1:0] LEN_CAP =
        dfc_pkg::LENGTH_W'((MAX_FRAME_BYTES - 1 < LEN_TOP) ? (MAX_FRAME_BYTES - 1) : LEN_TOP);

    logic [dfc_pkg::LENGTH_W-1:0] pos_reg;
    logic [dfc_pkg::LENF_W-1:0]   len_reg;
    logic [dfc_pkg::NUM_GRP-1:0]  mac_reg;
    logic [dfc_pkg::HDR_W-1:0]    hdr_reg;

    logic [dfc_pkg::LENGTH_W-1:0] pos_next;
    logic [dfc_pkg::LENF_W-1:0]   len_next;
    logic [dfc_pkg::NUM_GRP-1:0]  mac_next;
    logic [dfc_pkg::HDR_W-1:0]    hdr_next;
    logic [2:0]                   mac_idx;
    logic [1:0]                   llc_idx;
    logic [2:0]                   snap_idx;

    always_comb
    begin
        mac_idx  = pos_reg[2:0];
        llc_idx  = 2'(pos_reg - dfc_pkg::POS_LLC);
        snap_idx = 3'(pos_reg - dfc_pkg::POS_SNAP);
        mac_next = mac_reg;
        hdr_next = hdr_reg;
        len_next = len_reg;

        if (pos_reg < dfc_pkg::POS_MAC_END)
        begin
            for (int k = 0; k < dfc_pkg::NUM_GRP; k++)
            begin
                if (data_byte != dfc_pkg::MAC_PAT[k][mac_idx])
                    mac_next[k] = 1'b0;
            end
        end
        else if (pos_reg == dfc_pkg::POS_TYPE_HI || pos_reg == dfc_pkg::POS_TYPE_LO)
        begin
            len_next = {len_reg[dfc_pkg::BYTE_W-1:0], data_byte};
            if (data_byte != dfc_pkg::TYPE_PAT[pos_reg[0]])
                hdr_next[dfc_pkg::HDR_TYPE] = 1'b0;
        end
        else if (pos_reg >= dfc_pkg::POS_LLC && pos_reg < dfc_pkg::POS_SNAP)
        begin
            if (data_byte != dfc_pkg::LLC_PAT[llc_idx])
                hdr_next[dfc_pkg::HDR_LLC] = 1'b0;
        end
        else if (pos_reg >= dfc_pkg::POS_SNAP && pos_reg < dfc_pkg::POS_SNAP_END)
        begin
            for (int k = 0; k < dfc_pkg::NUM_GRP; k++)
            begin
                if (data_byte != dfc_pkg::SNAP_PAT[k][snap_idx])
                    hdr_next[dfc_pkg::HDR_SNAP + k] = 1'b0;
            end
        end

        if (pos_reg < LEN_CAP)
            pos_next = pos_reg + 1'b1;
        else
            pos_next = pos_reg;

        status.count        = pos_next;
        status.length_field = len_next;
        status.mac_flags    = mac_next;
        status.hdr_flags    = hdr_next;
    end

    // The status of a frame returns to its start values once its last byte is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            len_reg <= '0;
            mac_reg <= '1;
            hdr_reg <= '1;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                pos_reg <= '0;
                len_reg <= '0;
                mac_reg <= '1;
                hdr_reg <= '1;
            end
            else
            begin
                pos_reg <= pos_next;
                len_reg <= len_next;
                mac_reg <= mac_next;
                hdr_reg <= hdr_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/dfc_classify.sv =====
// Classification of a finished frame from its match flags and byte count.
// Depends on dfc_pkg for the status and verdict structs and the class codes.
`default_nettype none

module dfc_classify
(
    input  wire dfc_pkg::frame_status_t status,
    input  wire logic                  icmp_reply,
    output dfc_pkg::verdict_t          verdict
);

    logic                        grp_hit;
    logic [1:0]                  grp;
    logic [dfc_pkg::LENF_W-1:0]  count_ext;
    logic                        len_ok;
    logic                        snap_ok;

    always_comb
    begin
        grp_hit = 1'b0;
        grp     = 2'd0;
        if (status.count >= dfc_pkg::POS_MAC_END)
        begin
            if (status.mac_flags[0])
            begin
                grp_hit = 1'b1;
                grp     = 2'd0;
            end
            else if (status.mac_flags[1])
            begin
                grp_hit = 1'b1;
                grp     = 2'd1;
            end
            else if (status.mac_flags[2])
            begin
                grp_hit = 1'b1;
                grp     = 2'd2;
            end
        end

        count_ext = dfc_pkg::LENF_W'(status.count);
        len_ok    = (status.count >= dfc_pkg::POS_LLC) &&
                    (status.length_field == count_ext - dfc_pkg::LENF_W'(14));
        snap_ok   = (status.count >= dfc_pkg::POS_SNAP_END) &&
                    status.hdr_flags[dfc_pkg::HDR_SNAP + 32'(grp)];

        if (!grp_hit)
        begin
            verdict.frame_class    = icmp_reply ? dfc_pkg::CLS_ICMP : dfc_pkg::CLS_OTHER;
            verdict.payload_offset = dfc_pkg::OFF_ETH;
        end
        else if (grp == 2'd2 && status.count >= dfc_pkg::POS_LLC &&
                 status.hdr_flags[dfc_pkg::HDR_TYPE])
        begin
            verdict.frame_class    = dfc_pkg::CLS_LLDP_ETH;
            verdict.payload_offset = dfc_pkg::OFF_LLC;
        end
        else if (!len_ok)
        begin
            verdict.frame_class    = dfc_pkg::CLS_INCOMPLETE;
            verdict.payload_offset = dfc_pkg::OFF_LLC;
        end
        else if (status.count < dfc_pkg::POS_SNAP || !status.hdr_flags[dfc_pkg::HDR_LLC])
        begin
            verdict.frame_class    = dfc_pkg::CLS_UNKNOWN_LLC;
            verdict.payload_offset = dfc_pkg::OFF_LLC;
        end
        else
        begin
            verdict.payload_offset = dfc_pkg::OFF_SNAP;
            if (snap_ok)
                verdict.frame_class = dfc_pkg::frame_class_t'({2'b00, grp});
            else
                verdict.frame_class = dfc_pkg::CLS_UNKNOWN_SNAP;
        end

        verdict.counted = (verdict.frame_class <= dfc_pkg::CLS_OTHER);
    end

endmodule

`default_nettype wire

// ===== design/discovery_frame_classifier.sv =====
// Top level of the discovery frame classifier: byte tracking, classification,
// frame counter and result register. Depends on dfc_pkg and dfc_channels.
//
// Use: frame bytes arrive on the frame channel, one byte per word, starting at
// the destination MAC, with last_byte high on the final byte and icmp_reply
// sampled with it. Exactly one result word leaves on the result channel for
// each frame, carrying the class, the payload offset, the byte count
// (saturating at 2047) and the running count of accepted frames, which skips
// zero when it wraps.
// Throughput is one byte per cycle unless a last byte must wait: matching a
// byte is a single compare against fixed patterns between the tracking and
// result registers. Each result shows the cycle after its last byte is taken.
// Reset clears the frame tracking state, the frame counter and the valid flag
// of the result register; no result is pending afterwards.
// While the receiver stalls, bytes that are not last keep being accepted;
// only a last byte waits until the result register is free or being taken.
`default_nettype none

module discovery_frame_classifier
#(
    parameter int MAX_FRAME_BYTES = dfc_pkg::MAX_FRAME_BYTES
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    dfc_byte_if.sink        frame,
    dfc_result_if.source    result
);

    logic                   take;
    logic                   finish;
    dfc_pkg::frame_status_t status;
    dfc_pkg::verdict_t      verdict;

    logic [dfc_pkg::COUNT_W-1:0]  counter_reg;
    logic [dfc_pkg::COUNT_W-1:0]  counter_next;
    logic                         valid_reg;
    logic [dfc_pkg::CLASS_W-1:0]  class_reg;
    logic [dfc_pkg::OFFSET_W-1:0] offset_reg;
    logic [dfc_pkg::LENGTH_W-1:0] length_reg;

    // A last byte needs room in the result register; other bytes never do.
    assign frame.ready = !valid_reg || result.ready || !frame.last_byte;
    assign take        = frame.valid && frame.ready;
    assign finish      = take && frame.last_byte;

    dfc_frame_track
    #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    )
    u_track
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (frame.data_byte),
        .last_byte (frame.last_byte),
        .status    (status)
    );

    dfc_classify u_classify
    (
        .status     (status),
        .icmp_reply (frame.icmp_reply),
        .verdict    (verdict)
    );

    // The counter never returns to zero: it wraps from all ones to one.
    always_comb
    begin
        if (!verdict.counted)
            counter_next = counter_reg;
        else if (counter_reg == '1)
            counter_next = dfc_pkg::COUNT_W'(1);
        else
            counter_next = counter_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (finish)
            begin
                counter_reg <= counter_next;
                valid_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            class_reg  <= verdict.frame_class;
            offset_reg <= verdict.payload_offset;
            length_reg <= status.count;
        end
    end

    assign result.valid          = valid_reg;
    assign result.frame_class    = class_reg;
    assign result.payload_offset = offset_reg;
    assign result.frame_length   = length_reg;
    assign result.accepted_count = counter_reg;

endmodule

`default_nettype wire
